@@ src/sfr_pkg.sv @@
// Shared constants, types and helpers for the stream find/replace block.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int SFR_SEARCH_MAX  = 8;
   localparam int SFR_REPLACE_MAX = 8;
   localparam int TEXT_W          = 64;
   localparam int LEN_W           = 4;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_TEXT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_TEXT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LENGTH = 2'd3;

   typedef struct packed {
      logic is_prefix;
      logic is_full;
   } match_type;

   function automatic logic [7:0] byte_sel(input logic [TEXT_W-1:0] word,
                                           input logic [2:0] idx);
      byte_sel = word[idx*8 +: 8];
   endfunction

endpackage

@@ src/stream_find_replace_unit.sv @@
// Stream find/replace: top level with sequencer, hold buffer and output stage.
// Sequence: a word is accepted into the hold buffer, then the hold buffer is checked again
//   after each literal popped, the replacement bytes are emitted, the held bytes and a
//   terminator are flushed on the last word, and a closing step releases the staged word.
// Throughput: one input word in flight; the sequencer and its single compare unit set it.
// Reset (synchronous, active high) clears registers, hold count, sequencer and output valids.
`timescale 1ns / 1ps

module stream_find_replace_unit
   import sfr_pkg::*;
#(
   parameter int SEARCH_MAX  = SFR_SEARCH_MAX,
   parameter int REPLACE_MAX = SFR_REPLACE_MAX
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_end_of_string,
   output logic                 rsp_run_last,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TEXT_W-1:0]    csr_wdata
);

   localparam int CNT_W  = $clog2(SEARCH_MAX + 1);
   localparam int RIDX_W = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_REPL  = 6'b000100,
      S_FLUSH = 6'b001000,
      S_DONE  = 6'b010000,
      S_HOLD  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [TEXT_W-1:0] search_text_ff, search_text_in;
   logic [LEN_W-1:0]  search_length_ff, search_length_in;
   logic [TEXT_W-1:0] replace_text_ff, replace_text_in;
   logic [LEN_W-1:0]  replace_length_ff, replace_length_in;

   logic [7:0]        pend_ff [SEARCH_MAX];
   logic [7:0]        pend_in [SEARCH_MAX];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              last_ff, last_in;
   logic [RIDX_W-1:0] rep_idx_ff, rep_idx_in;

   // staged word waits here until we know whether it closes the run
   logic              stg_vld_ff, stg_vld_in;
   logic [7:0]        stg_byte_ff, stg_byte_in;
   logic              stg_bval_ff, stg_bval_in;
   logic              stg_eos_ff, stg_eos_in;

   logic              out_vld_ff, out_vld_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_bval_ff, out_bval_in;
   logic              out_eos_ff, out_eos_in;
   logic              out_last_ff, out_last_in;

   logic [SEARCH_MAX*8-1:0] pend_flat;
   logic [LEN_W-1:0]        slen;
   logic [LEN_W-1:0]        rlen;
   match_type               match;
   logic                    out_free;
   logic                    can_emit;
   logic                    emit;
   logic [7:0]              emit_byte;
   logic                    emit_bval;
   logic                    emit_eos;
   logic                    pop;
   state_type               post_state;

   always_comb begin
      for (int k = 0; k < SEARCH_MAX; k++) begin
         pend_flat[k*8 +: 8] = pend_ff[k];
      end
   end

   assign slen = (search_length_ff > LEN_W'(SEARCH_MAX)) ? LEN_W'(SEARCH_MAX)
                                                          : search_length_ff;
   assign rlen = (replace_length_ff > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX)
                                                            : replace_length_ff;

   sfr_match #(
      .SEARCH_MAX (SEARCH_MAX)
   ) u_match (
      .pend_bytes  (pend_flat),
      .pend_count  (cnt_ff),
      .search_text (search_text_ff),
      .search_len  (slen),
      .match       (match)
   );

   assign out_free   = !out_vld_ff || rsp_ready;
   assign can_emit   = !stg_vld_ff || out_free;
   assign post_state = last_ff ? S_FLUSH : S_DONE;
   assign req_ready  = (state_ff == S_IDLE);

   // configuration
   always_comb begin
      search_text_in    = search_text_ff;
      search_length_in  = search_length_ff;
      replace_text_in   = replace_text_ff;
      replace_length_in = replace_length_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SEARCH_TEXT:    search_text_in    = csr_wdata;
            CSR_SEARCH_LENGTH:  search_length_in  = csr_wdata[LEN_W-1:0];
            CSR_REPLACE_TEXT:   replace_text_in   = csr_wdata;
            CSR_REPLACE_LENGTH: replace_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      last_in     = last_ff;
      rep_idx_in  = rep_idx_ff;
      stg_vld_in  = stg_vld_ff;
      stg_byte_in = stg_byte_ff;
      stg_bval_in = stg_bval_ff;
      stg_eos_in  = stg_eos_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      out_byte_in = out_byte_ff;
      out_bval_in = out_bval_ff;
      out_eos_in  = out_eos_ff;
      out_last_in = out_last_ff;
      emit        = 1'b0;
      emit_byte   = pend_ff[0];
      emit_bval   = 1'b1;
      emit_eos    = 1'b0;
      pop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               for (int k = 0; k < SEARCH_MAX; k++) begin
                  if (CNT_W'(k) == cnt_ff) begin
                     pend_in[k] = req_in_byte;
                  end
               end
               cnt_in   = cnt_ff + CNT_W'(1);
               last_in  = req_in_last;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = post_state;
            end else if (match.is_prefix) begin
               if (match.is_full) begin
                  cnt_in = '0;
                  if (rlen != '0) begin
                     rep_idx_in = '0;
                     state_in   = S_REPL;
                  end else begin
                     state_in = post_state;
                  end
               end else begin
                  state_in = post_state;
               end
            end else if (can_emit) begin
               pop = 1'b1;
            end
         end
         S_REPL: begin
            if (can_emit) begin
               emit       = 1'b1;
               emit_byte  = byte_sel(replace_text_ff, 3'(rep_idx_ff));
               rep_idx_in = rep_idx_ff + RIDX_W'(1);
               if (LEN_W'(rep_idx_ff) == rlen - LEN_W'(1)) begin
                  state_in = post_state;
               end
            end
         end
         S_FLUSH: begin
            if (can_emit) begin
               if (cnt_ff == '0) begin
                  emit      = 1'b1;
                  emit_byte = 8'd0;
                  emit_bval = 1'b0;
                  emit_eos  = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (!stg_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_byte_in = stg_byte_ff;
               out_bval_in = stg_bval_ff;
               out_eos_in  = stg_eos_ff;
               out_last_in = 1'b1;
               stg_vld_in  = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // literal pop: oldest held byte goes out, the rest shift down
      if (pop) begin
         emit = 1'b1;
         for (int k = 0; k < SEARCH_MAX - 1; k++) begin
            pend_in[k] = pend_ff[k+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (emit) begin
         if (stg_vld_ff) begin
            out_vld_in  = 1'b1;
            out_byte_in = stg_byte_ff;
            out_bval_in = stg_bval_ff;
            out_eos_in  = stg_eos_ff;
            out_last_in = 1'b0;
         end
         stg_vld_in  = 1'b1;
         stg_byte_in = emit_byte;
         stg_bval_in = emit_bval;
         stg_eos_in  = emit_eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         search_text_ff    <= '0;
         search_length_ff  <= '0;
         replace_text_ff   <= '0;
         replace_length_ff <= '0;
         cnt_ff            <= '0;
         stg_vld_ff        <= 1'b0;
         out_vld_ff        <= 1'b0;
      end else begin
         state_ff          <= state_in;
         search_text_ff    <= search_text_in;
         search_length_ff  <= search_length_in;
         replace_text_ff   <= replace_text_in;
         replace_length_ff <= replace_length_in;
         cnt_ff            <= cnt_in;
         stg_vld_ff        <= stg_vld_in;
         out_vld_ff        <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      last_ff     <= last_in;
      rep_idx_ff  <= rep_idx_in;
      stg_byte_ff <= stg_byte_in;
      stg_bval_ff <= stg_bval_in;
      stg_eos_ff  <= stg_eos_in;
      out_byte_ff <= out_byte_in;
      out_bval_ff <= out_bval_in;
      out_eos_ff  <= out_eos_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_byte_valid    = out_bval_ff;
   assign rsp_end_of_string = out_eos_ff;
   assign rsp_run_last      = out_last_ff;

`ifndef ASSERT_OFF
   a_room_for_append: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff < CNT_W'(SEARCH_MAX)))
      else $error("hold buffer full while waiting for a word");

   a_stage_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stg_vld_ff)
      else $error("staged word left behind at end of run");

   a_term_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_string) |-> (rsp_run_last && !rsp_byte_valid))
      else $error("terminator word malformed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while one is in progress");
`endif

endmodule

@@ src/sfr_match.sv @@
// Compare unit: checks the held bytes against the search pattern.
`timescale 1ns / 1ps

module sfr_match
   import sfr_pkg::*;
#(
   parameter int SEARCH_MAX = SFR_SEARCH_MAX
) (
   input  logic [SEARCH_MAX*8-1:0]          pend_bytes,
   input  logic [$clog2(SEARCH_MAX+1)-1:0]  pend_count,
   input  logic [TEXT_W-1:0]                search_text,
   input  logic [LEN_W-1:0]                 search_len,
   output match_type                        match
);

   localparam int CNT_W = $clog2(SEARCH_MAX + 1);

   logic mismatch;
   logic fits;

   always_comb begin
      mismatch = 1'b0;
      for (int k = 0; k < SEARCH_MAX; k++) begin
         if ((CNT_W'(k) < pend_count) &&
             (pend_bytes[k*8 +: 8] != search_text[k*8 +: 8])) begin
            mismatch = 1'b1;
         end
      end
      fits = (LEN_W'(pend_count) <= search_len);
      match.is_prefix = fits && !mismatch;
      match.is_full   = fits && !mismatch && (LEN_W'(pend_count) == search_len);
   end

endmodule
